### src/pmpt_pkg.sv
`default_nettype none

package pmpt_pkg;

  localparam int unsigned Entries  = 256;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned OpW      = 3;
  localparam int unsigned IdW      = 8;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned StatusW  = 2;

  localparam logic [PrioW-1:0] PrioMax = {PrioW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OpAdd     = 3'd0,
    OpPromote = 3'd1,
    OpPop     = 3'd2,
    OpPeek    = 3'd3,
    OpLookup  = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2,
    StatBadId = 2'd3
  } status_e;

  // one access to the entry stores; read data is registered and comes back the cycle after
  typedef struct packed {
    logic                rd;
    logic                wr_pl;
    logic                wr_pr;
    logic [IdxW-1:0]     addr;
    logic [PayloadW-1:0] pl;
    logic [PrioW-1:0]    pr;
  } mem_req_t;

endpackage

`default_nettype wire

### src/pmpt_if.sv
`default_nettype none

interface pmpt_in_if;
  logic                          valid;
  logic                          ready;
  logic [pmpt_pkg::OpW-1:0]      op;
  logic [pmpt_pkg::IdW-1:0]      item_id;
  logic [pmpt_pkg::PayloadW-1:0] payload;

  modport source (output valid, op, item_id, payload, input ready);
  modport sink   (input valid, op, item_id, payload, output ready);
endinterface

interface pmpt_out_if;
  logic                          valid;
  logic                          ready;
  logic [pmpt_pkg::StatusW-1:0]  status;
  logic [pmpt_pkg::IdW-1:0]      result_id;
  logic [pmpt_pkg::PayloadW-1:0] result_payload;
  logic [pmpt_pkg::PrioW-1:0]    result_priority;
  logic                          id_present;

  modport source (output valid, status, result_id, result_payload, result_priority,
                  id_present, input ready);
  modport sink   (input valid, status, result_id, result_payload, result_priority,
                  id_present, output ready);
endinterface

`default_nettype wire

### src/promotable_max_priority_table_unit.sv
// Promotable max-priority table.
// in_i carries one command item (op, item_id, payload); out_o returns exactly
// one result item per command, in order. Both are valid/ready channels.
// States from acceptance to the output register, with the output free:
//   add, undefined op, failing id check, empty table : SFinish
//   promote, lookup                                  : SRead, SFinish
//   peek, pop : SScan over the ids handed out, SDrain, SFinish; the linear
//               scan reads one priority/payload entry per cycle.
// One command is in flight at a time; in_i.ready is high whenever no command
// is being worked on, even while a finished result still sits in the output
// register waiting for out_o.ready. A finished result waits for the output
// register to free up, so a stalled receiver holds off only the next-but-one
// command. Promote reads and writes back the same entry in successive cycles;
// nothing else can touch the store in between.
// Reset clears the present bits and the id counter at once; no clearing pass
// runs, so in_i.ready is high straight out of reset. Payload and
// priority entries are only ever read after an add has written them.
`default_nettype none

module promotable_max_priority_table_unit (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  pmpt_in_if.sink   in_i,
  pmpt_out_if.source out_o
);

  typedef enum logic [4:0] {
    SIdle   = 5'b00001,
    SRead   = 5'b00010,
    SScan   = 5'b00100,
    SDrain  = 5'b01000,
    SFinish = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [pmpt_pkg::Entries-1:0]  present_q, present_d;
  logic [pmpt_pkg::CntW-1:0]     next_id_q, next_id_d;
  logic [pmpt_pkg::OpW-1:0]      op_q, op_d;
  logic [pmpt_pkg::IdW-1:0]      id_q, id_d;
  logic [pmpt_pkg::IdxW-1:0]     scan_q, scan_d;
  logic                          vld_q, vld_d;
  logic [pmpt_pkg::IdxW-1:0]     vidx_q, vidx_d;
  logic                          found_q, found_d;
  logic [pmpt_pkg::IdxW-1:0]     best_idx_q, best_idx_d;
  logic [pmpt_pkg::PayloadW-1:0] best_pl_q, best_pl_d;
  logic [pmpt_pkg::PrioW-1:0]    best_pr_q, best_pr_d;

  logic [pmpt_pkg::StatusW-1:0]  res_st_q, res_st_d;
  logic [pmpt_pkg::IdW-1:0]      res_id_q, res_id_d;
  logic [pmpt_pkg::PayloadW-1:0] res_pl_q, res_pl_d;
  logic [pmpt_pkg::PrioW-1:0]    res_pr_q, res_pr_d;
  logic                          res_pres_q, res_pres_d;

  logic                          out_valid_q, out_valid_d;
  logic [pmpt_pkg::StatusW-1:0]  out_st_q, out_st_d;
  logic [pmpt_pkg::IdW-1:0]      out_id_q, out_id_d;
  logic [pmpt_pkg::PayloadW-1:0] out_pl_q, out_pl_d;
  logic [pmpt_pkg::PrioW-1:0]    out_pr_q, out_pr_d;
  logic                          out_pres_q, out_pres_d;

  pmpt_pkg::mem_req_t            mem_req;
  logic [pmpt_pkg::PayloadW-1:0] rd_pl;
  logic [pmpt_pkg::PrioW-1:0]    rd_pr;
  logic [pmpt_pkg::PrioW-1:0]    promoted;
  logic                          take;

  pmpt_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rd_pl_o (rd_pl),
    .rd_pr_o (rd_pr)
  );

  assign in_i.ready = (state_q == SIdle);
  assign promoted   = (rd_pr == pmpt_pkg::PrioMax) ? rd_pr : rd_pr + 1'b1;

  // compare stage of the scan: ">=" hands ties to the later (higher) id
  assign take = vld_q && (!found_q || (rd_pr >= best_pr_q));

  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    next_id_d   = next_id_q;
    op_d        = op_q;
    id_d        = id_q;
    scan_d      = scan_q;
    vld_d       = 1'b0;
    vidx_d      = vidx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_pl_d   = best_pl_q;
    best_pr_d   = best_pr_q;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    res_pl_d    = res_pl_q;
    res_pr_d    = res_pr_q;
    res_pres_d  = res_pres_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_st_d    = out_st_q;
    out_id_d    = out_id_q;
    out_pl_d    = out_pl_q;
    out_pr_d    = out_pr_q;
    out_pres_d  = out_pres_q;
    mem_req     = '0;

    if (take) begin
      found_d    = 1'b1;
      best_idx_d = vidx_q;
      best_pl_d  = rd_pl;
      best_pr_d  = rd_pr;
    end

    unique case (state_q)
      SIdle: begin
        if (in_i.valid) begin
          op_d       = in_i.op;
          id_d       = in_i.item_id;
          scan_d     = '0;
          found_d    = 1'b0;
          res_st_d   = pmpt_pkg::StatOk;
          res_id_d   = '0;
          res_pl_d   = '0;
          res_pr_d   = '0;
          res_pres_d = 1'b0;
          state_d    = SFinish;
          unique case (in_i.op)
            pmpt_pkg::OpAdd: begin
              if (next_id_q == pmpt_pkg::CntW'(pmpt_pkg::Entries)) begin
                res_st_d = pmpt_pkg::StatFull;
              end else begin
                mem_req.wr_pl = 1'b1;
                mem_req.wr_pr = 1'b1;
                mem_req.addr  = next_id_q[pmpt_pkg::IdxW-1:0];
                mem_req.pl    = in_i.payload;
                mem_req.pr    = '0;
                present_d[next_id_q[pmpt_pkg::IdxW-1:0]] = 1'b1;
                next_id_d  = next_id_q + 1'b1;
                res_id_d   = pmpt_pkg::IdW'(next_id_q[pmpt_pkg::IdxW-1:0]);
                res_pres_d = 1'b1;
              end
            end
            pmpt_pkg::OpPromote, pmpt_pkg::OpLookup: begin
              res_id_d = in_i.item_id;
              if (present_q[in_i.item_id]) begin
                mem_req.rd   = 1'b1;
                mem_req.addr = in_i.item_id;
                state_d      = SRead;
              end else begin
                res_st_d = pmpt_pkg::StatBadId;
              end
            end
            pmpt_pkg::OpPop, pmpt_pkg::OpPeek: begin
              if (next_id_q == '0) begin
                res_st_d = pmpt_pkg::StatEmpty;
              end else begin
                state_d = SScan;
              end
            end
            default: begin
            end
          endcase
        end
      end

      SRead: begin
        res_st_d   = pmpt_pkg::StatOk;
        res_pres_d = 1'b1;
        if (op_q == pmpt_pkg::OpPromote) begin
          mem_req.wr_pr = 1'b1;
          mem_req.addr  = id_q;
          mem_req.pr    = promoted;
          res_pr_d      = promoted;
        end else begin
          res_pl_d = rd_pl;
          res_pr_d = rd_pr;
        end
        state_d = SFinish;
      end

      SScan: begin
        mem_req.rd   = 1'b1;
        mem_req.addr = scan_q;
        vld_d        = present_q[scan_q];
        vidx_d       = scan_q;
        scan_d       = scan_q + 1'b1;
        if ({1'b0, scan_q} == next_id_q - 1'b1) begin
          state_d = SDrain;
        end
      end

      SDrain: begin
        // found_d and best_*_d include the last compare here
        if (found_d) begin
          res_st_d   = pmpt_pkg::StatOk;
          res_id_d   = pmpt_pkg::IdW'(best_idx_d);
          res_pl_d   = best_pl_d;
          res_pr_d   = best_pr_d;
          res_pres_d = (op_q == pmpt_pkg::OpPeek);
          if (op_q == pmpt_pkg::OpPop) begin
            present_d[best_idx_d] = 1'b0;
          end
        end else begin
          res_st_d   = pmpt_pkg::StatEmpty;
          res_id_d   = '0;
          res_pl_d   = '0;
          res_pr_d   = '0;
          res_pres_d = 1'b0;
        end
        state_d = SFinish;
      end

      SFinish: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_id_d    = res_id_q;
          out_pl_d    = res_pl_q;
          out_pr_d    = res_pr_q;
          out_pres_d  = res_pres_q;
          state_d     = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      present_q   <= '0;
      next_id_q   <= '0;
      vld_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      next_id_q   <= next_id_d;
      vld_q       <= vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    scan_q     <= scan_d;
    vidx_q     <= vidx_d;
    best_idx_q <= best_idx_d;
    best_pl_q  <= best_pl_d;
    best_pr_q  <= best_pr_d;
    res_st_q   <= res_st_d;
    res_id_q   <= res_id_d;
    res_pl_q   <= res_pl_d;
    res_pr_q   <= res_pr_d;
    res_pres_q <= res_pres_d;
    out_st_q   <= out_st_d;
    out_id_q   <= out_id_d;
    out_pl_q   <= out_pl_d;
    out_pr_q   <= out_pr_d;
    out_pres_q <= out_pres_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_st_q;
  assign out_o.result_id       = out_id_q;
  assign out_o.result_payload  = out_pl_q;
  assign out_o.result_priority = out_pr_q;
  assign out_o.id_present      = out_pres_q;

endmodule

`default_nettype wire

### src/pmpt_store.sv
`default_nettype none

module pmpt_store (
  input  wire logic                          clk_i,
  input  wire pmpt_pkg::mem_req_t            req_i,
  output logic      [pmpt_pkg::PayloadW-1:0] rd_pl_o,
  output logic      [pmpt_pkg::PrioW-1:0]    rd_pr_o
);

  logic [pmpt_pkg::PayloadW-1:0] pl_mem [pmpt_pkg::Entries];
  logic [pmpt_pkg::PrioW-1:0]    pr_mem [pmpt_pkg::Entries];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_pl) begin
      pl_mem[req_i.addr] <= req_i.pl;
    end
    if (req_i.rd) begin
      rd_pl_o <= pl_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_pr) begin
      pr_mem[req_i.addr] <= req_i.pr;
    end
    if (req_i.rd) begin
      rd_pr_o <= pr_mem[req_i.addr];
    end
  end

endmodule

`default_nettype wire

### src/pmpt_chk.sv
`default_nettype none

module pmpt_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [pmpt_pkg::StatusW-1:0]  status_i,
  input wire logic [pmpt_pkg::IdW-1:0]      result_id_i,
  input wire logic [pmpt_pkg::PayloadW-1:0] result_payload_i,
  input wire logic [pmpt_pkg::PrioW-1:0]    result_priority_i,
  input wire logic                          id_present_i
);

  // a pending result must hold until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(result_id_i) && $stable(result_payload_i) &&
      $stable(result_priority_i) && $stable(id_present_i))
    else $error("result changed while stalled");

  // one command at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command accepted while one is in flight");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == pmpt_pkg::StatFull) |->
      (result_id_i == '0) && (result_payload_i == '0) &&
      (result_priority_i == '0) && !id_present_i)
    else $error("full answer carries data");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == pmpt_pkg::StatEmpty) |->
      (result_id_i == '0) && (result_payload_i == '0) &&
      (result_priority_i == '0) && !id_present_i)
    else $error("empty answer carries data");

endmodule

bind promotable_max_priority_table_unit pmpt_chk u_pmpt_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .status_i          (out_o.status),
  .result_id_i       (out_o.result_id),
  .result_payload_i  (out_o.result_payload),
  .result_priority_i (out_o.result_priority),
  .id_present_i      (out_o.id_present)
);

`default_nettype wire
